// File: sv/u8san_pkg.sv
// Package for the UTF-8 sanitizer: item types, queue entry type, byte codes
// and default sizes. Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8san_pkg;

	// default sizes
	localparam int CAP_BITS_DEF   = 16;
	localparam int HOLD_DEPTH_DEF = 8;
	localparam int CAP_RESET      = 256;
	// depth of the front-to-back queue
	localparam int Q_DEPTH        = 4;

	// lead byte classes
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD_MIN    = 8'hC2;
	localparam logic [7:0] LEAD_MAX    = 8'hF4;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;

	// leads with a narrowed second-byte range
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;

	// continuation ranges
	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] CONT_HI = 8'hBF;
	localparam logic [7:0] E0_LO   = 8'hA0;
	localparam logic [7:0] ED_HI   = 8'h9F;
	localparam logic [7:0] F0_LO   = 8'h90;
	localparam logic [7:0] F4_HI   = 8'h8F;

	// U+FFFD and the cut mark
	localparam logic [7:0] REPL0 = 8'hEF;
	localparam logic [7:0] REPL1 = 8'hBF;
	localparam logic [7:0] REPL2 = 8'hBD;
	localparam logic [7:0] DOT   = 8'h2E;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_present;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_out;
		logic       was_clipped;
	} out_item_t;

	// one output action from the front: a character to send or to hold,
	// optionally closing the string
	typedef struct packed {
		logic [3:0][7:0] data;  // data[0] goes out first
		logic [2:0]      len;   // 0..4 bytes
		logic            hold;  // store in the hold buffer instead of sending
		logic            fin;   // string ends after this entry
		logic            cut;   // string was cut (on fin)
		logic            dots;  // capacity allows the "..." mark (on fin)
	} q_entry_t;

endpackage

`default_nettype wire

// File: sv/u8san_queue.sv
// Short FIFO of queue entries between the sanitizer front and back.
// Depends on u8san_pkg (q_entry_t, Q_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module u8san_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  u8san_pkg::q_entry_t  push_data,
	output logic                 full,
	input  wire                  pop,
	output u8san_pkg::q_entry_t  head,
	output logic                 empty
);
	import u8san_pkg::*;

	localparam int QP = $clog2(Q_DEPTH);
	localparam int QC = $clog2(Q_DEPTH + 1);

	q_entry_t        mem_q [Q_DEPTH];
	logic [QP-1:0]   wr_ptr_q;
	logic [QP-1:0]   rd_ptr_q;
	logic [QC-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = cnt_q == QC'(Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QP'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QP'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QP'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QP'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QC'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QC'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/u8san_front.sv
// Sanitizer front: accepts source items, runs the UTF-8 sequence checker and
// the capacity bookkeeping, and pushes output actions. Depends on u8san_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8san_front #(
	parameter int CAP_BITS = u8san_pkg::CAP_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_stall,
	input  u8san_pkg::in_item_t  byte_data,
	input  wire  [CAP_BITS-1:0]  cap_cfg,
	input  wire                  q_full,
	output logic                 q_push,
	output u8san_pkg::q_entry_t  q_data
);
	import u8san_pkg::*;

	typedef enum logic [1:0] {
		FE_RUN  = 2'b01,
		FE_REPL = 2'b10
	} fe_state_t;

	fe_state_t           st_q, st_n;
	logic [2:0]          seq_cnt_q, seq_cnt_n;
	logic [2:0]          seq_need_q, seq_need_n;
	logic [3:0][7:0]     seq_b_q, seq_b_n;
	logic [CAP_BITS-1:0] out_cnt_q, out_cnt_n;
	logic                holding_q, holding_n;
	logic                clip_q, clip_n;
	logic                in_str_q, in_str_n;
	logic [CAP_BITS-1:0] cap_q, cap_n;
	logic [1:0]          rem_q, rem_n;
	logic [7:0]          sv_b_q, sv_b_n;
	logic                sv_last_q, sv_last_n;

	logic [CAP_BITS-1:0] cap_use;
	logic                cap_ge5;
	logic                cap_zero;
	logic [7:0]          b;
	logic [7:0]          lo, hi;
	logic                in_rng;
	logic                acc, item_live, feed, rep_go;
	logic                cont_ok, complete, fail;
	logic                start_req;
	logic [7:0]          start_b;
	logic                st_ascii, st_bad;
	logic                pc_req;
	logic [2:0]          pc_w;
	logic [3:0][7:0]     pc_d;
	logic                end_req;
	logic [CAP_BITS:0]   nsum;
	logic [CAP_BITS+1:0] nsum4;
	logic                pc_over, pc_fit, pc_direct, pc_act, pc_push;
	logic                cut_w;

	assign b        = byte_data.in_byte;
	assign cap_use  = in_str_q ? cap_q : cap_cfg;
	assign cap_ge5  = cap_use >= CAP_BITS'(5);
	assign cap_zero = cap_use == '0;

	// input is held while failed-sequence replacements are worked off or the queue is full
	assign byte_stall = (st_q == FE_REPL) || q_full;

	// allowed range for the next continuation byte
	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (seq_cnt_q == 3'd1) begin
			unique case (seq_b_q[0])
				LEAD_E0: lo = E0_LO;
				LEAD_ED: hi = ED_HI;
				LEAD_F0: lo = F0_LO;
				LEAD_F4: hi = F4_HI;
				default: ;
			endcase
		end
	end
	assign in_rng = (b >= lo) && (b <= hi);

	// classify this cycle's work
	always_comb begin
		acc       = byte_valid && !byte_stall;
		item_live = acc && (byte_data.byte_present || byte_data.last_in);
		feed      = item_live && byte_data.byte_present && !cap_zero && !clip_q;
		rep_go    = (st_q == FE_REPL) && !q_full;
		cont_ok   = feed && (seq_cnt_q != 3'd0) && in_rng;
		complete  = cont_ok && ((seq_cnt_q + 3'd1) >= seq_need_q);
		fail      = feed && (seq_cnt_q != 3'd0) && !in_rng;

		start_req = 1'b0;
		start_b   = b;
		if (feed && seq_cnt_q == 3'd0) begin
			start_req = 1'b1;
		end else if (rep_go && rem_q == 2'd0 && !clip_q) begin
			start_req = 1'b1;
			start_b   = sv_b_q;
		end
		st_ascii = start_b < ASCII_LIMIT;
		st_bad   = (start_b < LEAD_MIN) || (start_b > LEAD_MAX);

		pc_req = complete || fail || (rep_go && rem_q != 2'd0) ||
			(start_req && (st_ascii || st_bad));

		// character to put: completed sequence, plain byte or U+FFFD
		pc_w = 3'd3;
		pc_d = {8'h00, REPL2, REPL1, REPL0};
		if (complete) begin
			pc_w = seq_need_q;
			for (int i = 0; i < 4; i++) begin
				pc_d[i] = (3'(i) == seq_cnt_q) ? b : seq_b_q[i];
			end
		end else if (start_req && st_ascii) begin
			pc_w = 3'd1;
			pc_d = {24'h000000, start_b};
		end

		end_req = (item_live && byte_data.last_in && !fail) ||
			(rep_go && rem_q == 2'd0 && sv_last_q);
	end

	// capacity checks for the character being put
	assign nsum      = (CAP_BITS+1)'(out_cnt_q) + (CAP_BITS+1)'(pc_w);
	assign nsum4     = (CAP_BITS+2)'(nsum) + (CAP_BITS+2)'(4);
	assign pc_over   = nsum >= (CAP_BITS+1)'(cap_use);
	assign pc_fit    = nsum4 <= (CAP_BITS+2)'(cap_use);
	assign pc_direct = cap_ge5 && !holding_q && pc_fit;
	assign pc_act    = pc_req && !clip_q;
	assign pc_push   = pc_act && !pc_over;

	// next state
	always_comb begin
		st_n       = st_q;
		seq_cnt_n  = seq_cnt_q;
		seq_need_n = seq_need_q;
		seq_b_n    = seq_b_q;
		out_cnt_n  = out_cnt_q;
		holding_n  = holding_q;
		clip_n     = clip_q;
		in_str_n   = in_str_q;
		cap_n      = cap_q;
		rem_n      = rem_q;
		sv_b_n     = sv_b_q;
		sv_last_n  = sv_last_q;
		cut_w      = 1'b0;

		// first item of a string latches the capacity
		if (item_live && !in_str_q) begin
			in_str_n = 1'b1;
			cap_n    = cap_cfg;
		end

		if (complete || fail) begin
			seq_cnt_n  = 3'd0;
			seq_need_n = 3'd0;
		end
		if (cont_ok && !complete) begin
			seq_b_n[seq_cnt_q[1:0]] = b;
			seq_cnt_n               = seq_cnt_q + 3'd1;
		end
		if (start_req && !st_ascii && !st_bad) begin
			seq_b_n[0] = start_b;
			seq_cnt_n  = 3'd1;
			seq_need_n = (start_b < LEAD3_MIN) ? 3'd2 :
				((start_b < LEAD4_MIN) ? 3'd3 : 3'd4);
		end

		// failed sequence: one replacement now, the rest and the re-lead later
		if (fail) begin
			st_n      = FE_REPL;
			rem_n     = 2'(seq_cnt_q - 3'd1);
			sv_b_n    = b;
			sv_last_n = byte_data.last_in;
		end
		if (rep_go) begin
			if (rem_q != 2'd0) begin
				rem_n = rem_q - 2'd1;
			end else begin
				st_n = FE_RUN;
			end
		end

		if (pc_act) begin
			if (pc_over) begin
				clip_n     = 1'b1;
				holding_n  = 1'b0;
				seq_cnt_n  = 3'd0;
				seq_need_n = 3'd0;
			end else begin
				out_cnt_n = out_cnt_q + CAP_BITS'(pc_w);
				holding_n = holding_q || !pc_direct;
			end
		end

		// end of string: an open sequence counts as a cut
		if (end_req) begin
			cut_w      = clip_n || (seq_cnt_n != 3'd0);
			seq_cnt_n  = 3'd0;
			seq_need_n = 3'd0;
			out_cnt_n  = '0;
			holding_n  = 1'b0;
			clip_n     = 1'b0;
			in_str_n   = 1'b0;
		end
	end

	// action to the back
	always_comb begin
		q_push      = pc_push || end_req;
		q_data.data = pc_d;
		q_data.len  = pc_push ? pc_w : 3'd0;
		q_data.hold = pc_push && !pc_direct;
		q_data.fin  = end_req;
		q_data.cut  = cut_w;
		q_data.dots = cap_ge5;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= FE_RUN;
			seq_cnt_q  <= '0;
			seq_need_q <= '0;
			out_cnt_q  <= '0;
			holding_q  <= 1'b0;
			clip_q     <= 1'b0;
			in_str_q   <= 1'b0;
			cap_q      <= '0;
			rem_q      <= '0;
			sv_last_q  <= 1'b0;
		end else begin
			st_q       <= st_n;
			seq_cnt_q  <= seq_cnt_n;
			seq_need_q <= seq_need_n;
			out_cnt_q  <= out_cnt_n;
			holding_q  <= holding_n;
			clip_q     <= clip_n;
			in_str_q   <= in_str_n;
			cap_q      <= cap_n;
			rem_q      <= rem_n;
			sv_last_q  <= sv_last_n;
		end
	end

	// sequence bytes and the saved failing byte
	always_ff @(posedge clk) begin
		seq_b_q <= seq_b_n;
		sv_b_q  <= sv_b_n;
	end

endmodule

`default_nettype wire

// File: sv/u8san_back.sv
// Sanitizer back: expands queue entries into output items one byte a cycle
// unless stalled, keeps the hold buffer, writes the string end. Uses u8san_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8san_back #(
	parameter int HOLD_DEPTH = u8san_pkg::HOLD_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_empty,
	input  u8san_pkg::q_entry_t   q_head,
	output logic                  q_pop,
	output logic                  res_valid,
	input  wire                   res_stall,
	output u8san_pkg::out_item_t  res_data
);
	import u8san_pkg::*;

	localparam int PW     = $clog2(HOLD_DEPTH);
	localparam int HCNT_W = $clog2(HOLD_DEPTH + 1);

	typedef enum logic [3:0] {
		BK_BODY  = 4'b0001,
		BK_DOTS  = 4'b0010,
		BK_FLUSH = 4'b0100,
		BK_MARK  = 4'b1000
	} bk_state_t;

	bk_state_t         bk_q, bk_n;
	logic [PW-1:0]     pos_q, pos_n;
	logic [HCNT_W-1:0] hc_q, hc_n;
	logic [7:0]        hold_q [HOLD_DEPTH];
	logic              hold_we [HOLD_DEPTH];
	logic [7:0]        hold_wd [HOLD_DEPTH];
	logic              res_valid_q;
	out_item_t         res_q;

	logic              ld_en, go, hwr, emit;
	out_item_t         e_item;
	logic [HCNT_W:0]   hc_sum;
	logic [HCNT_W-1:0] hc_add;
	bk_state_t         tgt_hold, tgt_dir;
	logic              more_dir, body_end, flush_end;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign ld_en     = !res_valid_q || !res_stall;
	assign go        = ld_en && !q_empty;

	// hold count after storing this entry
	assign hc_sum = (HCNT_W+1)'(hc_q) + (HCNT_W+1)'(q_head.len);
	assign hc_add = (hc_sum > (HCNT_W+1)'(HOLD_DEPTH)) ? HCNT_W'(HOLD_DEPTH) :
		hc_sum[HCNT_W-1:0];

	// where the string end goes on
	assign tgt_hold = q_head.cut ? (q_head.dots ? BK_DOTS : BK_MARK) :
		((hc_add != '0) ? BK_FLUSH : BK_MARK);
	assign tgt_dir  = q_head.cut ? (q_head.dots ? BK_DOTS : BK_MARK) :
		((hc_q != '0) ? BK_FLUSH : BK_MARK);
	assign more_dir = q_head.cut ? q_head.dots : (hc_q != '0);

	assign body_end  = ((PW+1)'(pos_q) + (PW+1)'(1)) == (PW+1)'(q_head.len);
	assign flush_end = (HCNT_W'(pos_q) + HCNT_W'(1)) == hc_q;

	// byte sequencer
	always_comb begin
		bk_n   = bk_q;
		pos_n  = pos_q;
		hc_n   = hc_q;
		q_pop  = 1'b0;
		hwr    = 1'b0;
		emit   = 1'b0;
		e_item = '{out_byte: 8'h00, has_byte: 1'b1, last_out: 1'b0, was_clipped: 1'b0};
		if (go) begin
			unique case (bk_q)
				BK_BODY: begin
					if (q_head.hold) begin
						hwr  = 1'b1;
						hc_n = hc_add;
						if (q_head.fin) begin
							bk_n = tgt_hold;
						end else begin
							q_pop = 1'b1;
						end
					end else if (q_head.len == 3'd0) begin
						if (q_head.fin) begin
							bk_n = tgt_dir;
						end else begin
							q_pop = 1'b1;
						end
					end else begin
						emit            = 1'b1;
						e_item.out_byte = q_head.data[pos_q[1:0]];
						if (body_end) begin
							pos_n = '0;
							if (q_head.fin && more_dir) begin
								bk_n = tgt_dir;
							end else begin
								q_pop = 1'b1;
								if (q_head.fin) begin
									e_item.last_out    = 1'b1;
									e_item.was_clipped = q_head.cut;
									hc_n               = '0;
								end
							end
						end else begin
							pos_n = pos_q + PW'(1);
						end
					end
				end
				BK_DOTS: begin
					emit            = 1'b1;
					e_item.out_byte = DOT;
					if (pos_q == PW'(2)) begin
						e_item.last_out    = 1'b1;
						e_item.was_clipped = 1'b1;
						q_pop              = 1'b1;
						hc_n               = '0;
						pos_n              = '0;
						bk_n               = BK_BODY;
					end else begin
						pos_n = pos_q + PW'(1);
					end
				end
				BK_FLUSH: begin
					emit            = 1'b1;
					e_item.out_byte = hold_q[pos_q];
					if (flush_end) begin
						e_item.last_out = 1'b1;
						q_pop           = 1'b1;
						hc_n            = '0;
						pos_n           = '0;
						bk_n            = BK_BODY;
					end else begin
						pos_n = pos_q + PW'(1);
					end
				end
				BK_MARK: begin
					// bare end marker
					emit               = 1'b1;
					e_item.has_byte    = 1'b0;
					e_item.last_out    = 1'b1;
					e_item.was_clipped = q_head.cut;
					q_pop              = 1'b1;
					hc_n               = '0;
					pos_n              = '0;
					bk_n               = BK_BODY;
				end
				default: begin
					bk_n = BK_BODY;
				end
			endcase
		end
	end

	// hold buffer write lanes
	always_comb begin
		for (int j = 0; j < HOLD_DEPTH; j++) begin
			hold_we[j] = 1'b0;
			hold_wd[j] = q_head.data[0];
			for (int i = 0; i < 4; i++) begin
				if (hwr && (3'(i) < q_head.len) &&
					((HCNT_W+1)'(hc_q) + (HCNT_W+1)'(i) == (HCNT_W+1)'(j))) begin
					hold_we[j] = 1'b1;
					hold_wd[j] = q_head.data[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < HOLD_DEPTH; j++) begin
			if (hold_we[j]) begin
				hold_q[j] <= hold_wd[j];
			end
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q  <= BK_BODY;
			pos_q <= '0;
			hc_q  <= '0;
		end else begin
			bk_q  <= bk_n;
			pos_q <= pos_n;
			hc_q  <= hc_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_en) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_en && emit) begin
			res_q <= e_item;
		end
	end

endmodule

`default_nettype wire

// File: sv/utf8_sanitize_truncate.sv
// Top level of the UTF-8 sanitizer with capacity limit and cut marking.
// Depends on u8san_pkg, u8san_front, u8san_queue and u8san_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a string one byte item at a time and gives strictly
// well-formed UTF-8, one byte item a cycle unless stalled. Bad bytes become
// EF BF BD; when the output would pass capacity - 1 bytes, or the string ends
// inside a sequence, the output backs up to a character boundary and ends in
// "..." if the capacity is at least 5. The capacity is sampled by the first
// item of each string. Without stalls, well-formed text flows at one byte per
// cycle: the front takes one item a cycle and the back sends one byte a cycle,
// with a four-entry queue between them. A replacement is three output bytes;
// a failed sequence holds the input while the front works off the remaining
// replacements and the retried byte. The back gives no output while it takes
// a closing queue entry that carries no byte, before the held bytes, the "..."
// mark or a bare end marker, and while it stores a character in the hold buffer.
module utf8_sanitize_truncate #(
	parameter int CAP_BITS   = u8san_pkg::CAP_BITS_DEF,
	parameter int HOLD_DEPTH = u8san_pkg::HOLD_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cap_we,
	input  wire  [CAP_BITS-1:0]   cap_wdata,
	input  wire                   byte_valid,
	output logic                  byte_stall,
	input  u8san_pkg::in_item_t   byte_data,
	output logic                  res_valid,
	input  wire                   res_stall,
	output u8san_pkg::out_item_t  res_data
);
	import u8san_pkg::*;

	logic [CAP_BITS-1:0] cap_cfg_q;
	logic                q_push, q_full, q_pop, q_empty;
	q_entry_t            q_in, q_head;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q <= CAP_BITS'(CAP_RESET);
		end else if (cap_we) begin
			cap_cfg_q <= cap_wdata;
		end
	end

	u8san_front #(
		.CAP_BITS (CAP_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.cap_cfg    (cap_cfg_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	u8san_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	u8san_back #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for utf8_sanitize_truncate: directed and random strings checked
// against a behavioral predictor of the sanitizer. Depends on u8san_pkg.
`timescale 1ns / 1ps

module tb;
	import u8san_pkg::*;

	localparam int CAP_W        = CAP_BITS_DEF;
	localparam int HOLD_MAX     = HOLD_DEPTH_DEF;
	localparam int STEP_MAX     = 16;
	localparam int SETTLE_CYC   = 16;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 90;
	localparam logic [3:0][7:0] REPL_CHAR = {8'h00, REPL2, REPL1, REPL0};

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cap_we;
	logic [CAP_W-1:0] cap_wdata;
	logic             byte_valid;
	logic             byte_stall;
	in_item_t         byte_data;
	logic             res_valid;
	logic             res_stall;
	out_item_t        res_data;

	utf8_sanitize_truncate u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap_we     (cap_we),
		.cap_wdata  (cap_wdata),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// expected output bytes and run status
	out_item_t   sanitized_q[$];
	out_item_t   step_res[$];
	logic [7:0]  text_q[$];
	int          errors = 0;
	int          fed_items = 0;
	int          burst_left = 0;

	// predictor state
	logic [CAP_W-1:0] cap_setting;
	int               cap_now;
	bit               open_str;
	logic [3:0][7:0]  seq_buf;
	int               seq_cnt;
	int               seq_len;
	int               out_len;
	logic [7:0]       hold_buf[HOLD_MAX];
	int               hold_cnt;
	bit               cut_flag;

	task automatic report_mismatch(input string what, input out_item_t exp_v,
		input out_item_t got_v);
		$display("MISMATCH %s: expected %0h/%0b/%0b/%0b got %0h/%0b/%0b/%0b at %0t", what,
			exp_v.out_byte, exp_v.has_byte, exp_v.last_out, exp_v.was_clipped,
			got_v.out_byte, got_v.has_byte, got_v.last_out, got_v.was_clipped, $realtime);
		errors++;
	endtask

	// ---------------- predictor ----------------
	function automatic void push_out(input logic [7:0] b, input logic has);
		out_item_t r;
		if (step_res.size() >= STEP_MAX)
			return;
		r.out_byte    = b;
		r.has_byte    = has;
		r.last_out    = 1'b0;
		r.was_clipped = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void mark_cut();
		cut_flag = 1'b1;
		hold_cnt = 0;
		seq_cnt  = 0;
		seq_len  = 0;
	endfunction

	// place one character: send it, hold it near the limit, or cut
	function automatic void put_char(input logic [3:0][7:0] c, input int w);
		if (cut_flag || cap_now == 0)
			return;
		if (out_len + w > cap_now - 1) begin
			mark_cut();
			return;
		end
		if (cap_now >= 5 && hold_cnt == 0 && out_len + w <= cap_now - 4) begin
			for (int k = 0; k < w; k++)
				push_out(c[k], 1'b1);
		end else begin
			for (int k = 0; k < w; k++)
				if (hold_cnt < HOLD_MAX) begin
					hold_buf[hold_cnt] = c[k];
					hold_cnt++;
				end
		end
		out_len += w;
	endfunction

	function automatic void start_char(input logic [7:0] b);
		logic [3:0][7:0] one;
		if (cut_flag)
			return;
		one = {24'h0, b};
		if (b < ASCII_LIMIT)
			put_char(one, 1);
		else if (b < LEAD_MIN || b > LEAD_MAX)
			put_char(REPL_CHAR, 3);
		else begin
			seq_buf[0] = b;
			seq_cnt    = 1;
			seq_len    = (b < LEAD3_MIN) ? 2 : ((b < LEAD4_MIN) ? 3 : 4);
		end
	endfunction

	function automatic void feed_byte(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		int         held;
		int         w;
		lo = CONT_LO;
		hi = CONT_HI;
		if (seq_cnt == 0) begin
			start_char(b);
			return;
		end
		// second byte of some leads has a narrower range
		if (seq_cnt == 1) begin
			if (seq_buf[0] == LEAD_E0)
				lo = E0_LO;
			else if (seq_buf[0] == LEAD_ED)
				hi = ED_HI;
			else if (seq_buf[0] == LEAD_F0)
				lo = F0_LO;
			else if (seq_buf[0] == LEAD_F4)
				hi = F4_HI;
		end
		if (b >= lo && b <= hi) begin
			seq_buf[seq_cnt] = b;
			seq_cnt++;
			if (seq_cnt >= seq_len) begin
				w       = seq_len;
				seq_cnt = 0;
				seq_len = 0;
				put_char(seq_buf, w);
			end
			return;
		end
		// failed sequence: replace each held byte, then retry b as a lead
		held    = seq_cnt;
		seq_cnt = 0;
		seq_len = 0;
		for (int k = 0; k < held; k++)
			put_char(REPL_CHAR, 3);
		start_char(b);
	endfunction

	function automatic void close_string();
		out_item_t r;
		bit        cut;
		if (seq_cnt > 0 && !cut_flag)
			mark_cut();
		cut = cut_flag;
		if (cut) begin
			if (cap_now >= 5)
				for (int k = 0; k < 3; k++)
					push_out(DOT, 1'b1);
		end else begin
			for (int k = 0; k < hold_cnt; k++)
				push_out(hold_buf[k], 1'b1);
		end
		if (step_res.size() == 0)
			push_out(8'h00, 1'b0);
		r             = step_res.pop_back();
		r.last_out    = 1'b1;
		r.was_clipped = cut;
		step_res.push_back(r);
		seq_cnt  = 0;
		seq_len  = 0;
		out_len  = 0;
		hold_cnt = 0;
		cut_flag = 1'b0;
		open_str = 1'b0;
	endfunction

	// expected results of one accepted input item
	function automatic void sanitize_item(input in_item_t it);
		step_res.delete();
		if (!it.byte_present && !it.last_in)
			return;
		if (!open_str) begin
			open_str = 1'b1;
			cap_now  = int'(cap_setting);
			seq_cnt  = 0;
			seq_len  = 0;
			out_len  = 0;
			hold_cnt = 0;
			cut_flag = 1'b0;
		end
		if (it.byte_present && cap_now != 0 && !cut_flag)
			feed_byte(it.in_byte);
		if (it.last_in)
			close_string();
		foreach (step_res[k])
			sanitized_q.push_back(step_res[k]);
	endfunction

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (sanitized_q.size() == 0) begin
				report_mismatch("unexpected item", '0, res_data);
			end else begin
				want = sanitized_q.pop_front();
				if (res_data !== want)
					report_mismatch("result item", want, res_data);
			end
		end
	end

	// receiver stall pattern: a mode of none, light, heavy or periodic, picked anew at random
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          stall_tick = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 80);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     res_stall <= 1'b0;
			STALL_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    res_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: res_stall <= ((stall_tick % 5) < 2);
			default:        res_stall <= 1'b0;
		endcase
	end

	// watchdog: no progress while work is pending
	int idle_cyc = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
				idle_cyc = 0;
			else if (byte_valid || sanitized_q.size() != 0) begin
				idle_cyc++;
				if (idle_cyc >= STALL_LIMIT) begin
					$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// ---------------- stimulus helpers ----------------
	function automatic in_item_t mk_item(input logic [7:0] b, input logic p, input logic l);
		in_item_t it;
		it.in_byte      = b;
		it.byte_present = p;
		it.last_in      = l;
		return it;
	endfunction

	// send one item; the sender may idle between bursts
	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_data  <= it;
		do
			@(posedge clk);
		while (byte_stall);
		sanitize_item(it);
	endtask

	task automatic release_input();
		byte_valid <= 1'b0;
		burst_left = 0;
	endtask

	// wait until every expected item has come and the back end has settled
	task automatic wait_idle();
		while (sanitized_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_capacity(input int value);
		cap_we    <= 1'b1;
		cap_wdata <= value[CAP_W-1:0];
		@(posedge clk);
		cap_we      <= 1'b0;
		cap_setting = value[CAP_W-1:0];
	endtask

	// send text_q as one string; empty items sprinkled in at the given odds
	task automatic send_text(input bit end_marker, input int empty_pct);
		int n;
		n = text_q.size();
		if (n == 0)
			end_marker = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < empty_pct)
				send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
			send_item(mk_item(text_q[i], 1'b1, !end_marker && i == n - 1));
			fed_items++;
		end
		if (end_marker) begin
			send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			fed_items++;
		end
	endtask

	function automatic void second_range(input logic [7:0] lead, output logic [7:0] lo,
		output logic [7:0] hi);
		lo = CONT_LO;
		hi = CONT_HI;
		if (lead == LEAD_E0)
			lo = E0_LO;
		else if (lead == LEAD_ED)
			hi = ED_HI;
		else if (lead == LEAD_F0)
			lo = F0_LO;
		else if (lead == LEAD_F4)
			hi = F4_HI;
	endfunction

	// append one random character: mostly well formed, some broken
	task automatic add_char();
		int         pick;
		int         need;
		int         conts;
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			text_q.push_back(8'($urandom_range(0, 8'h7F)));
			return;
		end
		if (pick >= 85) begin
			text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
			return;
		end
		if (pick < 50)
			lead = 8'($urandom_range(LEAD_MIN, LEAD3_MIN - 1));
		else if (pick < 65)
			lead = 8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
		else if (pick < 75)
			lead = 8'($urandom_range(LEAD4_MIN, LEAD_MAX));
		else
			lead = 8'($urandom_range(LEAD_MIN, LEAD_MAX));
		need = (lead < LEAD3_MIN) ? 2 : ((lead < LEAD4_MIN) ? 3 : 4);
		// a broken sequence stops short; the end or a next byte that is no fitting continuation breaks it
		conts = (pick < 75) ? need - 1 : $urandom_range(0, need - 2);
		text_q.push_back(lead);
		second_range(lead, lo, hi);
		for (int k = 0; k < conts; k++) begin
			text_q.push_back(k == 0 ? 8'($urandom_range(lo, hi)) :
				8'($urandom_range(CONT_LO, CONT_HI)));
		end
	endtask

	// ---------------- tests ----------------
	task automatic test_default_capacity();
		text_q = '{8'h41, 8'h7A};
		send_text(1'b0, 0);
		release_input();
		wait_idle();
	endtask

	// ASCII ends, lone continuation, bad leads, empty item and bare end marker
	task automatic test_byte_classes();
		set_capacity(65535);
		text_q = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF};
		send_text(1'b0, 0);
		send_item(mk_item(8'hA5, 1'b0, 1'b0));
		send_item(mk_item(8'h5A, 1'b0, 1'b1));
		fed_items++;
		release_input();
		wait_idle();
	endtask

	// narrowed second-byte ranges, pass and fail, with the failing byte retried
	task automatic test_narrow_ranges();
		text_q = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'hF0, 8'h8F,
			8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text(1'b0, 0);
		release_input();
		wait_idle();
	endtask

	// string ending inside a sequence, zero capacity, cut below and at 5
	task automatic test_cuts();
		text_q = '{8'hC2};
		send_text(1'b0, 0);
		release_input();
		wait_idle();
		set_capacity(0);
		text_q = '{8'h41, 8'h42};
		send_text(1'b0, 0);
		release_input();
		wait_idle();
		set_capacity(2);
		text_q = '{8'h41, 8'h42};
		send_text(1'b0, 0);
		release_input();
		wait_idle();
		set_capacity(5);
		text_q = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45};
		send_text(1'b0, 0);
		release_input();
		wait_idle();
	endtask

	task automatic test_random_strings();
		int caps[16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 16, 24, 256, 65535, 0};
		int sel;
		int nchars;
		int base;
		base = fed_items;
		while (fed_items - base < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 15);
			set_capacity(sel == 15 ? $urandom_range(0, 65535) : caps[sel]);
			repeat ($urandom_range(1, 3)) begin
				text_q.delete();
				nchars = $urandom_range(0, 10);
				repeat (nchars) add_char();
				send_text($urandom_range(0, 3) == 0, 10);
			end
			release_input();
			wait_idle();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cap_we     = 1'b0;
		cap_wdata  = '0;
		byte_valid = 1'b0;
		byte_data  = '0;
		res_stall  = 1'b0;
		// predictor reset
		cap_setting = CAP_W'(CAP_RESET);
		cap_now     = 0;
		open_str    = 1'b0;
		seq_buf     = '0;
		seq_cnt     = 0;
		seq_len     = 0;
		out_len     = 0;
		hold_cnt    = 0;
		cut_flag    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_default_capacity();
		test_byte_classes();
		test_narrow_ranges();
		test_cuts();
		test_random_strings();

		wait_idle();
		repeat (SETTLE_CYC) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
